### rtl/tpd_pkg.sv
package tpd_pkg;

    localparam int PIX_W     = 16;
    localparam int SQ_W      = 2 * PIX_W;
    localparam int SUM_W     = 36;
    localparam int TMR_W     = 8;
    localparam int ROLE_W    = 2;
    localparam int NUM_BUFS  = 3;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 36;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 80;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_MOTION_THR = 2'd0;
    localparam logic [CFG_AW-1:0] REG_BG_THR     = 2'd1;
    localparam logic [CFG_AW-1:0] REG_MOTION_TMO = 2'd2;

    localparam logic [SUM_W-1:0] MOTION_THR_RST = 36'd1000;
    localparam logic [SUM_W-1:0] BG_THR_RST     = 36'd1000;
    localparam logic [TMR_W-1:0] MOTION_TMO_RST = 8'd10;
    localparam logic [TMR_W-1:0] TIMER_RST      = 8'd100;
    localparam logic [TMR_W-1:0] TIMER_MAX      = 8'hFF;
    localparam logic [SUM_W-1:0] SUM_MAX        = {SUM_W{1'b1}};

    typedef logic [ROLE_W-1:0] role_t;

    localparam role_t ROLE_CUR_RST  = 2'd0;
    localparam role_t ROLE_LAST_RST = 2'd1;
    localparam role_t ROLE_BG_RST   = 2'd2;

    // Packed from the top bit down; room_empty lands in bit 0
    typedef struct packed {
        logic             bg_refreshed;
        logic [SUM_W-1:0] background_error;
        logic [SUM_W-1:0] motion_error;
        logic             room_empty;
    } result_t;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [SQ_W-1:0]  v);
        logic [SUM_W:0] r;
        r = {1'b0, s} + (SUM_W+1)'(v);
        return r[SUM_W] ? SUM_MAX : r[SUM_W-1:0];
    endfunction

endpackage

### rtl/tpd_ram.sv
module tpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old word on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/thermal_presence_detector.sv
// Thermal presence detector.
// Input stream (s_*): one pixel per beat, s_tdata[15:0] = pixel_value, s_tlast marks
// the last pixel of a frame. The PIXELS-th pixel closes a frame even without s_tlast.
// Output stream (m_*): one beat per frame, emitted after its last pixel:
// room_empty, motion_error, background_error, background_refreshed.
// Configuration: cfg_we/cfg_addr/cfg_wdata write motion threshold (0), background
// threshold (1) and motion timeout (2); write only while the block is idle.
// Throughput: one pixel per cycle unless a stall holds the pipe. The three frame
// buffers are RAMs, each read once per cycle at the incoming pixel position; a
// one-entry bypass covers the write of the preceding pixel, so there are no bubbles.
// Result: the beat shows on m_tvalid once the last pixel has passed the accumulate
// stage and loaded the output register; a stall can hold it in the accumulate stage.
// Reset (aresetn low, synchronous): thresholds 1000, timeout 10, motion timer 100,
// sums cleared, buffer roles restored, first-frame seeding armed. Buffer contents
// are not cleared; the first frame writes every position it covers into all three.
// Stall: a result waiting in the output register does not block input. Only when a
// second frame-end result is ready while the first is still held does s_tready drop
// and the whole pipe hold until m_tready takes the waiting beat.
module thermal_presence_detector #(
    parameter int PIXELS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input pixel stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tpd_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] pixel_value
    input  logic                             s_tlast,   // frame_end
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tpd_pkg::M_TDATA_W-1:0]    m_tdata,   // [0] room_empty,
                                                        // [36:1] motion_error,
                                                        // [72:37] background_error,
                                                        // [73] background_refreshed,
                                                        // [79:74] zero
    // configuration write port
    input  logic                             cfg_we,
    input  logic [tpd_pkg::CFG_AW-1:0]       cfg_addr,
    input  logic [tpd_pkg::CFG_DW-1:0]       cfg_wdata
);

    import tpd_pkg::*;

    localparam int CNT_W = $clog2(PIXELS);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(PIXELS - 1);

    // configuration
    logic [SUM_W-1:0] motion_thr_reg;
    logic [SUM_W-1:0] bg_thr_reg;
    logic [TMR_W-1:0] motion_tmo_reg;

    // input side
    logic [CNT_W-1:0] cnt_reg;
    logic             s_acc;
    logic             s_end;

    // accumulate stage
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [CNT_W-1:0] s1_pos_reg;
    logic             s1_end_reg;
    logic             advance;
    logic             stall;
    logic             s1_go;

    // frame buffers
    logic [NUM_BUFS-1:0] buf_we;
    logic [NUM_BUFS-1:0] byp_reg;
    logic [PIX_W-1:0]    byp_data_reg;
    logic [PIX_W-1:0]    buf_rd [NUM_BUFS];
    logic [PIX_W-1:0]    buf_q  [NUM_BUFS];
    logic [PIX_W-1:0]    last_q;
    logic [PIX_W-1:0]    bg_q;

    // frame state
    role_t            role_cur_reg;
    role_t            role_last_reg;
    role_t            role_bg_reg;
    logic [SUM_W-1:0] mo_sum_reg;
    logic [SUM_W-1:0] bg_sum_reg;
    logic [SUM_W-1:0] mo_sum_next;
    logic [SUM_W-1:0] bg_sum_next;
    logic [TMR_W-1:0] timer_reg;
    logic [TMR_W-1:0] timer_eff;
    logic             first_reg;
    logic             motion_hit;
    logic             empty_pre;
    logic             refresh;
    logic             empty;

    // output register
    logic             m_valid_reg;
    result_t          result_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motion_thr_reg <= MOTION_THR_RST;
            bg_thr_reg     <= BG_THR_RST;
            motion_tmo_reg <= MOTION_TMO_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MOTION_THR: motion_thr_reg <= cfg_wdata[SUM_W-1:0];
                REG_BG_THR:     bg_thr_reg     <= cfg_wdata[SUM_W-1:0];
                REG_MOTION_TMO: motion_tmo_reg <= cfg_wdata[TMR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    // Hold everything when a second result is due and the output is still full
    assign stall    = s1_valid_reg && s1_end_reg && m_valid_reg && !m_tready;
    assign advance  = !stall;
    assign s_tready = advance;
    assign s_acc    = s_tvalid && s_tready;
    assign s1_go    = s1_valid_reg && advance;
    assign s_end    = s_tlast || (cnt_reg == LAST_POS);

    // Pixel position counter: wrap on frame end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (s_acc) begin
            cnt_reg <= s_end ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_pix_reg <= s_tdata[PIX_W-1:0];
            s1_pos_reg <= cnt_reg;
            s1_end_reg <= s_end;
        end
    end

    // ---------------- frame buffers ----------------
    // First frame seeds all three buffers; afterwards only the current one is written
    for (genvar i = 0; i < NUM_BUFS; i++) begin : g_buf
        assign buf_we[i] = s1_go && (first_reg || (role_cur_reg == ROLE_W'(i)));

        tpd_ram #(
            .WIDTH (PIX_W),
            .DEPTH (PIXELS)
        ) u_ram (
            .aclk  (aclk),
            .we    (buf_we[i]),
            .waddr (s1_pos_reg),
            .wdata (s1_pix_reg),
            .re    (advance),
            .raddr (cnt_reg),
            .rdata (buf_rd[i])
        );

        // Forward the pixel written in the same cycle the read was issued
        always_ff @(posedge aclk) begin
            if (advance) begin
                byp_reg[i] <= buf_we[i] && (s1_pos_reg == cnt_reg);
            end
        end

        assign buf_q[i] = byp_reg[i] ? byp_data_reg : buf_rd[i];
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            byp_data_reg <= s1_pix_reg;
        end
    end

    always_comb begin
        case (role_last_reg)
            2'd0:    last_q = buf_q[0];
            2'd1:    last_q = buf_q[1];
            default: last_q = buf_q[2];
        endcase
        case (role_bg_reg)
            2'd0:    bg_q = buf_q[0];
            2'd1:    bg_q = buf_q[1];
            default: bg_q = buf_q[2];
        endcase
    end

    // ---------------- accumulate and decide ----------------
    always_comb begin
        if (first_reg) begin
            mo_sum_next = mo_sum_reg;
            bg_sum_next = bg_sum_reg;
        end else begin
            mo_sum_next = sat_add(mo_sum_reg, sq_diff(s1_pix_reg, last_q));
            bg_sum_next = sat_add(bg_sum_reg, sq_diff(s1_pix_reg, bg_q));
        end

        // Motion restarts the timer; occupied while it is below the timeout
        motion_hit = mo_sum_next > motion_thr_reg;
        timer_eff  = motion_hit ? '0 : timer_reg;
        empty_pre  = timer_eff >= motion_tmo_reg;
        refresh    = empty_pre && (bg_sum_next < bg_thr_reg);
        empty      = empty_pre && !(bg_sum_next > bg_thr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mo_sum_reg    <= '0;
            bg_sum_reg    <= '0;
            timer_reg     <= TIMER_RST;
            first_reg     <= 1'b1;
            role_cur_reg  <= ROLE_CUR_RST;
            role_last_reg <= ROLE_LAST_RST;
            role_bg_reg   <= ROLE_BG_RST;
        end else if (s1_go) begin
            if (s1_end_reg) begin
                mo_sum_reg <= '0;
                bg_sum_reg <= '0;
                timer_reg  <= (timer_eff == TIMER_MAX) ? timer_eff : timer_eff + 1'b1;
                first_reg  <= 1'b0;
                // Current becomes last; on refresh last becomes background
                role_last_reg <= role_cur_reg;
                if (refresh) begin
                    role_bg_reg  <= role_last_reg;
                    role_cur_reg <= role_bg_reg;
                end else begin
                    role_cur_reg <= role_last_reg;
                end
            end else begin
                mo_sum_reg <= mo_sum_next;
                bg_sum_reg <= bg_sum_next;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_go && s1_end_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && s1_end_reg) begin
            result_reg.room_empty       <= empty;
            result_reg.motion_error     <= mo_sum_next;
            result_reg.background_error <= bg_sum_next;
            result_reg.bg_refreshed     <= refresh;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - $bits(result_t))'(0), result_reg};

    // ---------------- assertions ----------------
    // The three buffer roles always name three different buffers
    a_roles_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (role_cur_reg != role_last_reg) && (role_cur_reg != role_bg_reg)
        && (role_last_reg != role_bg_reg))
        else $error("buffer roles overlap");

    // Motion above threshold at a frame end leaves the timer at one
    a_timer_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_go && s1_end_reg && !first_reg && motion_hit) |=> (timer_reg == TMR_W'(1)))
        else $error("motion timer did not restart");

    // Leaving the seeding frame always produces a result beat
    a_first_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(first_reg) |-> m_tvalid)
        else $error("first frame ended without a result");

    // A result is never loaded over one that was not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s1_go || !s1_end_reg)
        else $error("pending result overwritten");

endmodule

### verif/tb_top.sv
module tb_top;

    import tpd_pkg::*;

    localparam int FRAME_PIX    = 16;
    localparam int MAX_CYCLES   = 1000000;  // hard stop for the whole run
    localparam int DRAIN_LIMIT  = 5000;     // cycles to wait for results still due
    localparam int SETTLE_CYC   = 6;        // pipe has an accumulate stage and an output register; allow margin
    localparam int LONG_HOLD    = 300;      // long back-pressure stretch on the result side
    localparam int HOLD_AT_A    = 25;       // start a long hold after this many verdicts
    localparam int HOLD_AT_B    = 70;
    localparam int N_PHASES     = 8;
    localparam int PHASE_BEATS  = 144;      // random pixel beats per register setting

    localparam logic [SUM_W-1:0]  THR_HIGH  = 36'd68718428160;
    localparam logic [CFG_AW-1:0] REG_SPARE = 2'd3;  // unmapped index, must be ignored

    typedef struct packed {
        logic             fe;
        logic [PIX_W-1:0] px;
    } pixel_beat_t;

    // Content styles of a generated frame
    typedef enum int {SHOT_QUIET, SHOT_MOTION, SHOT_JUMP, SHOT_EXTREME, SHOT_NOISE} shot_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [15:0] pixel_value
    logic                 s_tlast   = 1'b0; // frame_end
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [0] room_empty, [36:1] motion_error,
                                            // [72:37] background_error,
                                            // [73] background_refreshed
    logic                 cfg_we    = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr  = '0;
    logic [CFG_DW-1:0]    cfg_wdata = '0;

    thermal_presence_detector #(
        .PIXELS   (FRAME_PIX)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Occupancy tracker: mirrors the block's frame stores, sums, timer and
    // registers, and produces the verdict expected at each frame end.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] frame_store [NUM_BUFS][FRAME_PIX];
    role_t            cur_buf      = ROLE_CUR_RST;
    role_t            last_buf     = ROLE_LAST_RST;
    role_t            bg_buf       = ROLE_BG_RST;
    int               pix_pos      = 0;
    logic [SUM_W-1:0] motion_acc   = '0;
    logic [SUM_W-1:0] bg_acc       = '0;
    logic [TMR_W-1:0] quiet_frames = TIMER_RST;
    bit               seeding      = 1'b1;
    logic [SUM_W-1:0] motion_limit = MOTION_THR_RST;
    logic [SUM_W-1:0] bg_limit     = BG_THR_RST;
    logic [TMR_W-1:0] quiet_needed = MOTION_TMO_RST;

    result_t verdicts_due[$];      // verdicts predicted but not yet seen on m_*
    pixel_beat_t pixels_pending[$];  // beats waiting for the driver

    int errors          = 0;
    int beats_queued    = 0;
    int beats_taken     = 0;
    int verdicts_seen   = 0;
    int empties_seen    = 0;
    int refreshes_seen  = 0;
    int settings_used   = 0;
    int gen_pos         = 0;       // frame position of the next generated beat
    bit tx_steady       = 1'b0;    // sender offers every cycle when set
    bit rx_steady       = 1'b0;    // receiver accepts every cycle when set, outside the long holds

    function automatic longint unsigned sq_err(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        longint unsigned d;
        d = (a > b) ? longint'(a) - longint'(b) : longint'(b) - longint'(a);
        return d * d;
    endfunction

    function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] acc,
                                                 input longint unsigned v);
        longint unsigned r;
        r = longint'(acc) + v;
        return (r > longint'(SUM_MAX)) ? SUM_MAX : r[SUM_W-1:0];
    endfunction

    function automatic void track_pixel(input logic [PIX_W-1:0] px, input logic fe);
        int      p;
        bit      empty;
        bit      refresh;
        role_t   t;
        result_t v;
        p = (pix_pos >= FRAME_PIX) ? FRAME_PIX - 1 : pix_pos;
        // First frame seeds every store; later ones compare and overwrite current
        if (seeding) begin
            for (int b = 0; b < NUM_BUFS; b++) frame_store[b][p] = px;
        end else begin
            motion_acc = add_sat(motion_acc, sq_err(px, frame_store[last_buf][p]));
            bg_acc     = add_sat(bg_acc, sq_err(px, frame_store[bg_buf][p]));
            frame_store[cur_buf][p] = px;
        end
        if (!fe && p < FRAME_PIX - 1) begin
            pix_pos = p + 1;
            return;
        end
        // Frame closed: decide, then rotate the stores
        if (motion_acc > motion_limit) quiet_frames = '0;
        empty   = (quiet_frames >= quiet_needed);
        refresh = empty && (bg_acc < bg_limit);
        if (bg_acc > bg_limit) empty = 1'b0;
        v.room_empty       = empty;
        v.motion_error     = motion_acc;
        v.background_error = bg_acc;
        v.bg_refreshed     = refresh;
        verdicts_due.push_back(v);
        empties_seen   += empty;
        refreshes_seen += refresh;
        if (refresh) begin
            t        = bg_buf;
            bg_buf   = last_buf;
            last_buf = cur_buf;
            cur_buf  = t;
        end else begin
            t        = last_buf;
            last_buf = cur_buf;
            cur_buf  = t;
        end
        if (quiet_frames != TIMER_MAX) quiet_frames++;
        motion_acc = '0;
        bg_acc     = '0;
        pix_pos    = 0;
        seeding    = 1'b0;
    endfunction

    function automatic void check_verdict(input result_t got);
        result_t want;
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            errors++;
            return;
        end
        want = verdicts_due.pop_front();
        if (got.room_empty !== want.room_empty) begin
            $display("%0t: room_empty expected %0d, got %0d",
                     $time, want.room_empty, got.room_empty);
            errors++;
        end
        if (got.motion_error !== want.motion_error) begin
            $display("%0t: motion_error expected %0d, got %0d",
                     $time, want.motion_error, got.motion_error);
            errors++;
        end
        if (got.background_error !== want.background_error) begin
            $display("%0t: background_error expected %0d, got %0d",
                     $time, want.background_error, got.background_error);
            errors++;
        end
        if (got.bg_refreshed !== want.bg_refreshed) begin
            $display("%0t: background_refreshed expected %0d, got %0d",
                     $time, want.bg_refreshed, got.bg_refreshed);
            errors++;
        end
    endfunction

    // Idle length: mostly short, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued pixels, hold each beat until taken, insert gaps.
    // The tracker advances on every accepted beat.
    // ------------------------------------------------------------------
    pixel_beat_t cur_beat;
    int          gap_cnt = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                track_pixel(cur_beat.px, cur_beat.fe);
                beats_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    s_tvalid <= 1'b0;
                end else if (pixels_pending.size() > 0) begin
                    cur_beat = pixels_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_beat.px;
                    s_tlast  <= cur_beat.fe;
                    gap_cnt  = (tx_steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every result beat, drive m_tready with random stalls
    // and two long holds that back the block up into its input.
    // ------------------------------------------------------------------
    int stall_cnt = 0;
    int hold_cnt  = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_verdict(result_t'(m_tdata[$bits(result_t)-1:0]));
                if (verdicts_seen == HOLD_AT_A || verdicts_seen == HOLD_AT_B)
                    hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                m_tready <= 1'b0;
            end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
                stall_cnt = idle_len() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] scene [FRAME_PIX];

    function automatic void queue_beat(input logic [PIX_W-1:0] px, input logic fe);
        pixel_beat_t b;
        b.px = px;
        b.fe = fe;
        pixels_pending.push_back(b);
        beats_queued++;
        // Track where the block will be in its frame, to close frames at phase ends
        if (fe || gen_pos == FRAME_PIX - 1) gen_pos = 0;
        else gen_pos++;
    endfunction

    function automatic logic [PIX_W-1:0] clamp_px(input int x);
        if (x < 0) return '0;
        if (x > 65535) return 16'hFFFF;
        return x[PIX_W-1:0];
    endfunction

    // One frame: mostly well formed with a closing frame_end, some cut short,
    // some full length without frame_end, some pure noise with random frame_end bits
    function automatic void queue_frame();
        int               r;
        int               len;
        int               sel;
        logic             fe_last;
        bit               noise_fe;
        shot_t            shot;
        logic [PIX_W-1:0] v;
        noise_fe = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 72) begin
            len = FRAME_PIX;
            fe_last = 1'b1;
        end else if (r < 84) begin
            len = $urandom_range(1, FRAME_PIX - 1);
            fe_last = 1'b1;
        end else if (r < 92) begin
            len = FRAME_PIX;
            fe_last = 1'b0;
        end else begin
            len = $urandom_range(1, FRAME_PIX);
            fe_last = 1'b0;
            noise_fe = 1'b1;
        end
        r = $urandom_range(0, 99);
        shot = (r < 55) ? SHOT_QUIET : (r < 80) ? SHOT_MOTION : (r < 88) ? SHOT_JUMP :
               (r < 93) ? SHOT_EXTREME : SHOT_NOISE;
        sel = $urandom_range(0, 2);
        if (shot == SHOT_JUMP) begin
            // Someone walks in or the scene changes wholesale
            r = $urandom_range(0, 1);
            for (int k = 0; k < FRAME_PIX; k++)
                scene[k] = r ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(2600, 3200));
        end
        for (int k = 0; k < len; k++) begin
            case (shot)
                SHOT_QUIET: v = clamp_px(int'(scene[k]) + int'($urandom_range(0, 4)) - 2);
                SHOT_MOTION: begin
                    if ($urandom_range(0, 3) == 0)
                        v = clamp_px(int'(scene[k]) + ($urandom_range(0, 1) ? 1 : -1) *
                                     int'($urandom_range(50, 3000)));
                    else
                        v = scene[k];
                end
                SHOT_EXTREME: v = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF :
                                  (k[0] ? 16'hFFFF : 16'h0000);
                SHOT_NOISE: v = 16'($urandom_range(0, 65535));
                default: v = scene[k];
            endcase
            queue_beat(v, noise_fe ? 1'($urandom_range(0, 1)) :
                              ((k == len - 1) ? fe_last : 1'b0));
        end
    endfunction

    function automatic logic [SUM_W-1:0] pick_limit();
        int               r;
        longint unsigned  w;
        r = $urandom_range(0, 99);
        if (r < 40) return 36'($urandom_range(0, 5000));
        if (r < 75) return 36'($urandom_range(0, 2000000));
        if (r < 90) begin
            w = {28'd0, 4'($urandom_range(0, 15)), 32'($urandom)};
            return 36'(w % (longint'(THR_HIGH) + 1));
        end
        return THR_HIGH;
    endfunction

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_MOTION_THR: motion_limit = val;
            REG_BG_THR:     bg_limit     = val;
            REG_MOTION_TMO: quiet_needed = val[TMR_W-1:0];
            default: ;  // unmapped index: no register changes
        endcase
    endtask

    // Wait until every queued beat is taken and every verdict has arrived,
    // then let the pipe run dry before touching registers or stopping
    task automatic settle();
        int n;
        while (beats_taken != beats_queued) @(posedge aclk);
        n = 0;
        while (verdicts_due.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        if (verdicts_due.size() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time, verdicts_due.size());
            errors += verdicts_due.size();
            verdicts_due.delete();
        end
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [PIX_W-1:0] px;
        logic [SUM_W-1:0] lim_m;
        logic [SUM_W-1:0] lim_b;
        logic [TMR_W-1:0] tmo;
        int               phase_start;

        for (int k = 0; k < FRAME_PIX; k++) scene[k] = 16'($urandom_range(2600, 3200));
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Seed frame: full length with no frame_end, so the PIXELS-th pixel closes
        // it; alternate all-zero and all-one pixels
        for (int k = 0; k < FRAME_PIX; k++) queue_beat(k[0] ? 16'hFFFF : 16'h0000, 1'b0);
        // Early frame end after three pixels, maximum differences first
        queue_beat(16'hFFFF, 1'b0);
        queue_beat(16'h0000, 1'b0);
        queue_beat(16'h8000, 1'b1);
        settle();

        // Errors exactly equal to both thresholds: no restart, no refresh, no
        // occupancy from the background; timeout 0 makes the room count empty
        px    = frame_store[last_buf][0] + 16'd7;
        lim_m = 36'(sq_err(px, frame_store[last_buf][0]));
        lim_b = 36'(sq_err(px, frame_store[bg_buf][0]));
        write_reg(REG_MOTION_THR, lim_m);
        write_reg(REG_BG_THR, lim_b);
        write_reg(REG_MOTION_TMO, '0);
        settings_used++;
        queue_beat(px, 1'b1);
        settle();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    lim_m = '0;
                    lim_b = '0;
                    tmo   = '0;
                end
                1: begin
                    lim_m = THR_HIGH;
                    lim_b = THR_HIGH;
                    tmo   = 8'hFF;
                end
                2: begin
                    lim_m = 36'($urandom_range(0, 3000));
                    lim_b = 36'($urandom_range(0, 200000));
                    tmo   = 8'($urandom_range(0, 15));
                end
                default: begin
                    lim_m = pick_limit();
                    lim_b = pick_limit();
                    tmo   = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 20)) :
                                                         8'($urandom_range(0, 255));
                end
            endcase
            if (ph == 3) write_reg(REG_SPARE, {4'($urandom), 32'($urandom)});
            write_reg(REG_MOTION_THR, lim_m);
            write_reg(REG_BG_THR, lim_b);
            write_reg(REG_MOTION_TMO, tmo);
            settings_used++;
            // Some phases run without idling on one or both sides
            tx_steady = (ph % 4 == 3) || (ph == 5);
            rx_steady = (ph % 4 == 3) || (ph == 6);
            phase_start = beats_queued;
            while (beats_queued - phase_start < PHASE_BEATS) queue_frame();
            // Close any open frame so registers change only between frames
            if (gen_pos != 0) queue_beat(16'($urandom_range(0, 65535)), 1'b1);
            settle();
        end

        $display("Run covered %0d pixel beats and %0d verdicts (%0d empty, %0d refreshed)",
                 beats_taken, verdicts_seen, empties_seen, refreshes_seen);
        $display("under %0d register settings, with two long result-side holds.",
                 settings_used);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(2 * MAX_CYCLES);
        $display("Verification failed");
        $finish;
    end

endmodule
